// ===== design/hlm_pkg.sv =====
`default_nettype none

package hlm_pkg;

  localparam int unsigned NUM_SUBSYSTEMS_DEF = 8;
  localparam int unsigned ALIVE_W            = 8;
  localparam int unsigned MASK_W             = 8;
  localparam int unsigned IDX_W              = 3;
  localparam int unsigned TIME_W             = 32;
  localparam int unsigned CFG_ADDR_W         = 2;
  localparam int unsigned CFG_DATA_W         = 32;
  localparam int unsigned S_TDATA_W          = 48;
  localparam int unsigned M_TDATA_W          = 48;

  localparam logic [TIME_W-1:0] RST_FRESH_MS   = 32'd3000;
  localparam logic [TIME_W-1:0] RST_HEALTHY_MS = 32'd30000;
  localparam logic [IDX_W-1:0]  RST_LINK_BIT   = 3'd2;

  typedef enum logic {
    FUNC_PING = 1'b0,
    FUNC_BEAT = 1'b1
  } func_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_REQ_BITS       = 2'd0,
    REG_FRESH_WINDOW   = 2'd1,
    REG_HEALTHY_THRESH = 2'd2,
    REG_LINK_BIT_INDEX = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    func_e              func;
    logic [MASK_W-1:0]  ping_mask;
    logic [TIME_W-1:0]  now_ms;
    logic               link_up;
  } item_t;

  typedef struct packed {
    logic [ALIVE_W-1:0] req_bits;
    logic [TIME_W-1:0]  fresh_window_ms;
    logic [TIME_W-1:0]  healthy_hold_ms;
    logic [IDX_W-1:0]   link_bit_index;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/heartbeat_liveness_monitor.sv =====
// Heartbeat liveness monitor for up to eight subsystems.
// Input stream (s_axis): tuser selects ping (0) or heartbeat (1); tdata carries the
// ping mask, the millisecond time and the link-up flag. A ping stamps the time into
// the entry of the lowest set mask bit and gives no result. A heartbeat gives one
// result on the output stream (m_axis): alive mask, beat count after increment and
// a one-shot confirm flag once the required bits have stayed alive long enough.
// Configuration: cfg_valid_i/cfg_addr_i/cfg_data_i write one register per cycle
// (0 required mask, 1 freshness window, 2 healthy threshold, 3 link bit index);
// cfg_ready_o is always high. Write only while no item is in flight.
// Latency: a heartbeat goes through the input register, then the result register,
// to m_axis. Throughput: one item per cycle while m_axis does not stall, set by the
// single input register feeding eight parallel age compares and the result register.
// Reset clears all stamps (never pinged), the beat counter, the healthy timer and
// the confirm flag, and loads the register defaults.
// When the receiver stalls the result is held; pings keep flowing, and a heartbeat
// waits in the input register, after which s_axis_tready drops.
`default_nettype none

module heartbeat_liveness_monitor #(
  parameter int unsigned NumSubsystems = hlm_pkg::NUM_SUBSYSTEMS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] ping_mask, [39:8] now_ms, [40] link_up, [47:41] zero
  input  logic [hlm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] func
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] live_bits, [39:8] beat_count, [40] confirm_boot, [47:41] zero
  output logic [hlm_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hlm_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [hlm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import hlm_pkg::*;

  cfg_t               cfg_q;
  item_t              item_q;
  logic               in_valid_q;
  logic               advance;
  logic               is_beat;
  logic [ALIVE_W-1:0] alive;
  logic [TIME_W-1:0]  beat_count;
  logic               confirm;
  logic               out_valid_q;
  logic [ALIVE_W-1:0] out_alive_q;
  logic [TIME_W-1:0]  out_beat_q;
  logic               out_confirm_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.req_bits        <= '0;
      cfg_q.fresh_window_ms <= RST_FRESH_MS;
      cfg_q.healthy_hold_ms <= RST_HEALTHY_MS;
      cfg_q.link_bit_index  <= RST_LINK_BIT;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_REQ_BITS:       cfg_q.req_bits        <= cfg_data_i[ALIVE_W-1:0];
        REG_FRESH_WINDOW:   cfg_q.fresh_window_ms <= cfg_data_i[TIME_W-1:0];
        REG_HEALTHY_THRESH: cfg_q.healthy_hold_ms <= cfg_data_i[TIME_W-1:0];
        REG_LINK_BIT_INDEX: cfg_q.link_bit_index  <= cfg_data_i[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // a ping never needs the output register, so it always drains
  assign is_beat       = (item_q.func == FUNC_BEAT);
  assign advance       = in_valid_q && (!is_beat || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.func      <= func_e'(s_axis_tuser);
      item_q.ping_mask <= s_axis_tdata[7:0];
      item_q.now_ms    <= s_axis_tdata[39:8];
      item_q.link_up   <= s_axis_tdata[40];
    end
  end

  hlm_alive #(
    .NumSubsystems(NumSubsystems)
  ) u_alive (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ping_we_i(advance && !is_beat),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .alive_o  (alive)
  );

  hlm_health u_health (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_we_i   (advance && is_beat),
    .now_ms_i    (item_q.now_ms),
    .alive_i     (alive),
    .cfg_i       (cfg_q),
    .beat_count_o(beat_count),
    .confirm_o   (confirm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_beat) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_beat) begin
      out_alive_q   <= alive;
      out_beat_q    <= beat_count;
      out_confirm_q <= confirm;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_confirm_q, out_beat_q, out_alive_q};

endmodule

`default_nettype wire

// ===== design/hlm_alive.sv =====
`default_nettype none

module hlm_alive #(
  parameter int unsigned NumSubsystems = hlm_pkg::NUM_SUBSYSTEMS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         ping_we_i,
  input  hlm_pkg::item_t               item_i,
  input  hlm_pkg::cfg_t                cfg_i,
  output logic [hlm_pkg::ALIVE_W-1:0]  alive_o
);
  import hlm_pkg::*;

  // Only the first eight subsystems can ever be pinged through an 8-bit mask
  localparam int unsigned StoreN = (NumSubsystems < ALIVE_W) ? NumSubsystems : ALIVE_W;

  logic [IDX_W-1:0]   low_idx;
  logic               mask_any;
  logic [ALIVE_W-1:0] fresh;

  always_comb begin
    low_idx = '0;
    for (int i = ALIVE_W - 1; i >= 0; i--) begin
      if (item_i.ping_mask[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end

  assign mask_any = |item_i.ping_mask;

  for (genvar g = 0; g < ALIVE_W; g++) begin : g_entry
    if (g < StoreN) begin : g_store
      logic [TIME_W-1:0] stamp_q;
      logic [TIME_W-1:0] age;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          stamp_q <= '0;
        end else if (ping_we_i && mask_any && (low_idx == IDX_W'(g))) begin
          stamp_q <= item_i.now_ms;
        end
      end

      // a zero stamp means never pinged
      assign age      = item_i.now_ms - stamp_q;
      assign fresh[g] = (stamp_q != '0) && (age < cfg_i.fresh_window_ms);
    end else begin : g_none
      assign fresh[g] = 1'b0;
    end
  end

  always_comb begin
    alive_o = fresh;
    alive_o[cfg_i.link_bit_index] = item_i.link_up;
  end

endmodule

`default_nettype wire

// ===== design/hlm_health.sv =====
`default_nettype none

module hlm_health (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         beat_we_i,
  input  logic [hlm_pkg::TIME_W-1:0]   now_ms_i,
  input  logic [hlm_pkg::ALIVE_W-1:0]  alive_i,
  input  hlm_pkg::cfg_t                cfg_i,
  output logic [hlm_pkg::TIME_W-1:0]   beat_count_o,
  output logic                         confirm_o
);
  import hlm_pkg::*;

  logic [TIME_W-1:0] beat_q, beat_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic              confirmed_q, confirmed_d;
  logic              all_req;
  logic [TIME_W-1:0] held;

  assign all_req = (alive_i & cfg_i.req_bits) == cfg_i.req_bits;
  assign held    = now_ms_i - start_q;

  always_comb begin
    beat_d      = beat_q + TIME_W'(1);
    start_d     = start_q;
    confirmed_d = confirmed_q;
    confirm_o   = 1'b0;
    if (!confirmed_q) begin
      if (all_req) begin
        if (start_q == '0) begin
          start_d = now_ms_i;
        end else if (held >= cfg_i.healthy_hold_ms) begin
          confirmed_d = 1'b1;
          confirm_o   = 1'b1;
        end
      end else begin
        // dip: restart the timer
        start_d = '0;
      end
    end
  end

  assign beat_count_o = beat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= '0;
      start_q     <= '0;
      confirmed_q <= 1'b0;
    end else if (beat_we_i) begin
      beat_q      <= beat_d;
      start_q     <= start_d;
      confirmed_q <= confirmed_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/hlm_checker.sv =====
`default_nettype none

module hlm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [hlm_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
  import hlm_pkg::*;

  logic              out_acc;
  logic              seen_out_q;
  logic              seen_confirm_q;
  logic [TIME_W-1:0] last_beat_q;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_out_q     <= 1'b0;
      seen_confirm_q <= 1'b0;
      last_beat_q    <= '0;
    end else if (out_acc) begin
      seen_out_q     <= 1'b1;
      seen_confirm_q <= seen_confirm_q || m_axis_tdata[40];
      last_beat_q    <= m_axis_tdata[39:8];
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  a_confirm_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tdata[40]) |-> !seen_confirm_q)
    else $error("confirm pulse repeated");

  a_first_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !seen_out_q) |-> (m_axis_tdata[39:8] == TIME_W'(1)))
    else $error("first beat count after reset is not one");

  a_beat_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && seen_out_q) |-> (m_axis_tdata[39:8] == last_beat_q + TIME_W'(1)))
    else $error("beat count skipped or repeated");

endmodule

bind heartbeat_liveness_monitor hlm_checker u_hlm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

// ===== verif/heartbeat_liveness_monitor_test.sv =====
module heartbeat_liveness_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hlm_pkg::*;

  localparam int unsigned SETTLE          = 4;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 168;
  localparam int unsigned CONFIRM_PHASE   = 6;
  localparam int unsigned CYCLE_LIMIT     = 100000;
  localparam int unsigned DIRECTED_ROWS   = 21;

  typedef struct packed {
    logic [ALIVE_W-1:0] alive;
    logic [TIME_W-1:0]  beats;
    logic               confirm;
  } beat_report_t;

  typedef struct packed {
    logic         is_write;
    cfg_reg_e     wreg;
    logic [31:0]  wdata;
    item_t        item;
    logic         known;
    beat_report_t want;
  } plan_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [7:0] ping_mask, [39:8] now_ms, [40] link_up, [47:41] zero
  logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
  // [0] func
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [7:0] live_bits, [39:8] beat_count, [40] confirm_boot, [47:41] zero
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  heartbeat_liveness_monitor dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_addr_i,
    .cfg_data_i
  );

  // shadow of the monitor state
  logic [TIME_W-1:0] stamp [NUM_SUBSYSTEMS_DEF] = '{default: '0};
  logic [TIME_W-1:0] beats_seen    = '0;
  logic [TIME_W-1:0] healthy_since = '0;
  logic              confirmed     = 1'b0;
  cfg_t              live_cfg      = '{req_bits: '0, fresh_window_ms: RST_FRESH_MS,
                                       healthy_hold_ms: RST_HEALTHY_MS,
                                       link_bit_index: RST_LINK_BIT};

  beat_report_t due_reports [$];
  int unsigned  mismatches = 0;
  int unsigned  cycles     = 0;
  logic         no_gaps    = 1'b0;
  plan_row_t    directed_plan [DIRECTED_ROWS];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic track_item(input item_t it);
    logic [ALIVE_W-1:0] alive;
    logic [TIME_W-1:0]  age;
    beat_report_t       rep;
    int unsigned        slot;
    int unsigned        i;
    if (it.func == FUNC_PING) begin
      if (it.ping_mask != '0) begin
        slot = 0;
        while (!it.ping_mask[slot]) slot++;
        stamp[slot] = it.now_ms;
      end
    end else begin
      alive = '0;
      for (i = 0; i < NUM_SUBSYSTEMS_DEF; i++) begin
        age = it.now_ms - stamp[i];
        if (stamp[i] != '0 && age < live_cfg.fresh_window_ms) alive[i] = 1'b1;
      end
      alive[live_cfg.link_bit_index] = it.link_up;
      beats_seen++;
      rep.confirm = 1'b0;
      if (!confirmed) begin
        if ((alive & live_cfg.req_bits) == live_cfg.req_bits) begin
          // a zero start time means not yet sustained
          if (healthy_since == '0) begin
            healthy_since = it.now_ms;
          end else if (TIME_W'(it.now_ms - healthy_since) >= live_cfg.healthy_hold_ms) begin
            confirmed   = 1'b1;
            rep.confirm = 1'b1;
          end
        end else begin
          healthy_since = '0;
        end
      end
      rep.alive = alive;
      rep.beats = beats_seen;
      due_reports.push_back(rep);
    end
  endtask

  task automatic send_item(input item_t it);
    while (!no_gaps && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.func;
    s_axis_tdata  <= {7'd0, it.link_up, it.now_ms, it.ping_mask};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_item(it);
  endtask

  // drop valid, wait for every due report, then let any ping in flight settle
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [31:0] d);
    quiesce();
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= r;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (r)
      REG_REQ_BITS:       live_cfg.req_bits        = d[ALIVE_W-1:0];
      REG_FRESH_WINDOW:   live_cfg.fresh_window_ms = d;
      REG_HEALTHY_THRESH: live_cfg.healthy_hold_ms = d;
      REG_LINK_BIT_INDEX: live_cfg.link_bit_index  = d[IDX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_report(input logic [M_TDATA_W-1:0] data);
    beat_report_t want;
    if (due_reports.size() == 0) begin
      $error("beat report with none due: %h", data);
      mismatches++;
    end else begin
      want = due_reports.pop_front();
      if (data[7:0] !== want.alive) begin
        $error("live_bits: expected %h, got %h", want.alive, data[7:0]);
        mismatches++;
      end
      if (data[39:8] !== want.beats) begin
        $error("beat_count: expected %0d, got %0d", want.beats, data[39:8]);
        mismatches++;
      end
      if (data[40] !== want.confirm) begin
        $error("confirm_boot: expected %b, got %b", want.confirm, data[40]);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_report(m_axis_tdata);
    m_axis_tready <= no_gaps || ($urandom_range(99) >= 11);
  end

  function automatic plan_row_t ping_row(input logic [7:0] mask, input logic [31:0] now);
    plan_row_t r;
    r                = '0;
    r.item.func      = FUNC_PING;
    r.item.ping_mask = mask;
    r.item.now_ms    = now;
    return r;
  endfunction

  function automatic plan_row_t beat_row(input logic [31:0] now, input logic link,
                                         input logic known, input logic [7:0] alive,
                                         input logic [31:0] beats);
    plan_row_t r;
    r              = '0;
    r.item.func    = FUNC_BEAT;
    r.item.now_ms  = now;
    r.item.link_up = link;
    r.known        = known;
    r.want.alive   = alive;
    r.want.beats   = beats;
    return r;
  endfunction

  function automatic plan_row_t write_row(input cfg_reg_e r_sel, input logic [31:0] d);
    plan_row_t r;
    r          = '0;
    r.is_write = 1'b1;
    r.wreg     = r_sel;
    r.wdata    = d;
    return r;
  endfunction

  initial begin
    item_t         it;
    logic [31:0]   clock_ms;
    logic [31:0]   win;
    logic [31:0]   thresh;
    int unsigned   step_cap;
    int unsigned   pick;
    int unsigned   ph;
    int unsigned   n;

    directed_plan = '{
      beat_row(32'd0, 1'b0, 1'b1, 8'h00, 32'd1),      // time zero leaves the timer idle
      beat_row(32'd100, 1'b1, 1'b1, 8'h04, 32'd2),
      ping_row(8'h00, 32'd50),                        // zero mask, ignored
      ping_row(8'hFF, 32'd1000),
      ping_row(8'h80, 32'd2000),
      ping_row(8'h06, 32'd0),                         // stamp of zero reads as never pinged
      beat_row(32'd2500, 1'b0, 1'b1, 8'h81, 32'd3),
      beat_row(32'd4000, 1'b0, 1'b1, 8'h80, 32'd4),   // age equal to window is stale
      beat_row(32'd30099, 1'b1, 1'b1, 8'h04, 32'd5),  // one short of the threshold
      write_row(REG_REQ_BITS, 32'h02),
      beat_row(32'd30200, 1'b1, 1'b1, 8'h04, 32'd6),  // dip
      write_row(REG_LINK_BIT_INDEX, 32'd7),
      ping_row(8'h02, 32'hFFFF_FFF0),
      beat_row(32'h10, 1'b0, 1'b1, 8'h02, 32'd7),     // age across the time wrap
      write_row(REG_HEALTHY_THRESH, 32'hFFFF_FFFF),
      write_row(REG_FRESH_WINDOW, 32'hFFFF_FFFF),
      beat_row(32'hFFFF_FFFF, 1'b1, 1'b0, 8'h00, 32'd0),
      write_row(REG_FRESH_WINDOW, 32'd0),
      beat_row(32'd5, 1'b1, 1'b1, 8'h80, 32'd9),      // zero window, link bit only
      write_row(REG_LINK_BIT_INDEX, 32'd0),
      beat_row(32'd6, 1'b0, 1'b1, 8'h00, 32'd10)
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[k]) begin
      if (directed_plan[k].is_write) begin
        write_reg(directed_plan[k].wreg, directed_plan[k].wdata);
      end else begin
        send_item(directed_plan[k].item);
        // replace the prediction with the value read straight off the behaviour
        if (directed_plan[k].known) begin
          due_reports[due_reports.size() - 1] = directed_plan[k].want;
        end
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) win = 32'd1;
      else if (ph == 1) win = 32'hFFFF_FFFF;
      else begin
        case ($urandom_range(2))
          0:       win = $urandom_range(2, 3000);
          1:       win = $urandom_range(3000, 60000);
          default: win = $urandom();
        endcase
      end
      // hold confirmation off until late so that dips and restarts get exercised
      if (ph == CONFIRM_PHASE) thresh = 32'd0;
      else if (ph == CONFIRM_PHASE - 1) thresh = $urandom_range(1, 20000);
      else if (ph > CONFIRM_PHASE) thresh = $urandom();
      else thresh = 32'hFFFF_FFFF;

      write_reg(REG_REQ_BITS, (ph == 0) ? 32'hFF :
                (ph == CONFIRM_PHASE) ? 32'h00 : ($urandom() & $urandom()));
      write_reg(REG_FRESH_WINDOW, win);
      write_reg(REG_HEALTHY_THRESH, thresh);
      write_reg(REG_LINK_BIT_INDEX, $urandom_range(7));

      step_cap = (win > 32'd8000) ? 2000 : int'(win >> 2) + 1;
      clock_ms = $urandom();
      no_gaps  = (ph == 3);

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        clock_ms += $urandom_range(step_cap);
        it.func    = ($urandom_range(99) < 45) ? FUNC_PING : FUNC_BEAT;
        it.link_up = 1'($urandom_range(1));
        pick = $urandom_range(9);
        if (pick < 7) it.ping_mask = 8'(1 << $urandom_range(7));
        else if (pick < 9) it.ping_mask = 8'($urandom());
        else it.ping_mask = '0;
        pick = $urandom_range(99);
        if (pick < 4) it.now_ms = '0;
        else if (pick < 9) it.now_ms = $urandom();
        else it.now_ms = clock_ms;
        send_item(it);
      end
    end

    quiesce();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
